// ===== rtl/stcg_pkg.sv =====
package stcg_pkg;

   localparam int MAX_CHARS_DEF = 64;

   localparam int CODE_W = 8;
   localparam int LEN_W  = 7;
   localparam int IDX_W  = 7;
   localparam int OFF_W  = 3;
   localparam int COL_W  = 3;
   localparam int POS_W  = 10;
   localparam int GLYPH_W = 6;

   localparam logic [COL_W-1:0] LAST_COL  = 3'd6;
   localparam logic [OFF_W-1:0] SLOT_LAST = 3'd6;
   localparam logic [OFF_W-1:0] FONT_COLS = 3'd5;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_RENDER = 1'b1;

   localparam logic [GLYPH_W-1:0] DIGIT_BASE = 6'd26;
   localparam logic [GLYPH_W-1:0] FONT_BLANK = 6'd36;
   localparam logic [GLYPH_W-1:0] FONT_BANG  = 6'd37;
   localparam logic [GLYPH_W-1:0] FONT_DASH  = 6'd38;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // five rows per glyph, top row first; bit 4 is the leftmost font column
   localparam logic [4:0] FONT [39][5] = '{
      '{5'h1E,5'h11,5'h1F,5'h11,5'h11}, '{5'h1E,5'h11,5'h1E,5'h11,5'h1F},
      '{5'h1F,5'h10,5'h10,5'h10,5'h1F}, '{5'h1E,5'h11,5'h11,5'h11,5'h1E},
      '{5'h1F,5'h10,5'h1E,5'h10,5'h1F}, '{5'h1F,5'h10,5'h1C,5'h10,5'h10},
      '{5'h1F,5'h10,5'h13,5'h11,5'h1F}, '{5'h11,5'h11,5'h1F,5'h11,5'h11},
      '{5'h0E,5'h04,5'h04,5'h04,5'h0E}, '{5'h1F,5'h02,5'h02,5'h12,5'h1E},
      '{5'h11,5'h12,5'h1C,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h1F},
      '{5'h11,5'h1B,5'h15,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11},
      '{5'h1F,5'h11,5'h11,5'h11,5'h1F}, '{5'h1F,5'h11,5'h1F,5'h10,5'h10},
      '{5'h1E,5'h11,5'h11,5'h13,5'h1F}, '{5'h1F,5'h11,5'h1F,5'h14,5'h13},
      '{5'h1F,5'h10,5'h1F,5'h01,5'h1F}, '{5'h1F,5'h04,5'h04,5'h04,5'h04},
      '{5'h11,5'h11,5'h11,5'h11,5'h1F}, '{5'h11,5'h11,5'h11,5'h0A,5'h04},
      '{5'h11,5'h11,5'h15,5'h1B,5'h11}, '{5'h11,5'h0A,5'h04,5'h0A,5'h11},
      '{5'h11,5'h11,5'h1F,5'h04,5'h04}, '{5'h1F,5'h02,5'h04,5'h08,5'h1F},
      '{5'h1C,5'h14,5'h14,5'h14,5'h1C}, '{5'h08,5'h18,5'h08,5'h08,5'h1C},
      '{5'h1C,5'h04,5'h1C,5'h10,5'h1C}, '{5'h1C,5'h04,5'h1C,5'h04,5'h1C},
      '{5'h14,5'h14,5'h1C,5'h04,5'h04}, '{5'h1C,5'h10,5'h1C,5'h04,5'h1C},
      '{5'h1C,5'h10,5'h1C,5'h14,5'h1C}, '{5'h1C,5'h04,5'h04,5'h04,5'h04},
      '{5'h1C,5'h14,5'h1C,5'h14,5'h1C}, '{5'h1C,5'h14,5'h1C,5'h04,5'h04},
      '{5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h08,5'h08,5'h08,5'h00,5'h08},
      '{5'h00,5'h00,5'h1F,5'h00,5'h00}
   };

   function automatic logic [GLYPH_W-1:0] glyph_of(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] diff;
      logic [GLYPH_W-1:0] g;
      g = FONT_BLANK;
      if (code >= 8'h41 && code <= 8'h5A) begin
         diff = code - 8'h41;
         g = diff[GLYPH_W-1:0];
      end else if (code >= 8'h30 && code <= 8'h39) begin
         diff = code - 8'h30;
         g = diff[GLYPH_W-1:0] + DIGIT_BASE;
      end else if (code == 8'h21) begin
         g = FONT_BANG;
      end else if (code == 8'h2D) begin
         g = FONT_DASH;
      end
      return g;
   endfunction

   // bit r of the result is row r of the glyph at the given font column
   function automatic logic [4:0] font_column(input logic [GLYPH_W-1:0] g,
                                              input logic [OFF_W-1:0] off);
      logic [4:0] res;
      logic [OFF_W-1:0] bit_sel;
      res = '0;
      bit_sel = 3'd4 - off;
      if (off < FONT_COLS) begin
         for (int r = 0; r < 5; r++) begin
            res[r] = FONT[g][r][bit_sel];
         end
      end
      return res;
   endfunction

endpackage

// ===== rtl/scrolling_text_column_generator_core.sv =====
// write item: stored in the text memory at the edge where it is accepted
// render item: columns pass s1, then the result register; one per cycle unless stalled
// a frame of seven columns occupies the core for the accept cycle and one issue cycle per
// column; a stalled result port holds the column pipeline in place
// synchronous reset clears control state and message_length; text store is not cleared
module scrolling_text_column_generator_core #(
   parameter int MAX_CHARS = stcg_pkg::MAX_CHARS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        csr_wr_en,
   input  logic [stcg_pkg::LEN_W-1:0]  csr_wr_data,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [5:0]                  req_char_slot,
   input  logic [stcg_pkg::CODE_W-1:0] req_char_code,
   input  logic signed [stcg_pkg::POS_W-1:0] req_scroll_position,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [stcg_pkg::COL_W-1:0]  rsp_column_index,
   output logic [6:0]                  rsp_column_pixels,
   output logic                        rsp_last_column
);

   localparam int ADDR_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam int IDX_W  = stcg_pkg::IDX_W;
   localparam int OFF_W  = stcg_pkg::OFF_W;
   localparam int COL_W  = stcg_pkg::COL_W;

   stcg_pkg::state_type state_ff, state_in;

   logic [stcg_pkg::LEN_W-1:0] msg_len_ff;
   logic [COL_W-1:0]           col_ff, col_in;
   logic signed [10:0]         p_ff, p_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [OFF_W-1:0]           off_ff, off_in;

   logic                       s1_vld_ff, s1_vld_in;
   logic [COL_W-1:0]           s1_col_ff;
   logic [OFF_W-1:0]           s1_off_ff;
   logic                       s1_blank_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]           rsp_column_index_ff;
   logic [6:0]                 rsp_column_pixels_ff, rsp_column_pixels_in;
   logic                       rsp_last_column_ff;

   logic                       accept, render_acc, wr_en, advance, issue_en, issue;
   logic                       blank_now;
   logic [ADDR_W-1:0]          rd_addr;
   logic [stcg_pkg::CODE_W-1:0] rd_code;

   logic [8:0]                 pos9;
   logic [16:0]                prod;
   logic [IDX_W-1:0]           q_est, q_fix;
   logic [9:0]                 q7, rem_est, rem_adj;
   logic [OFF_W-1:0]           r_fix;
   logic [4:0]                 font_bits;

   assign accept     = req_valid && req_ready;
   assign render_acc = accept && (req_mode == stcg_pkg::MODE_RENDER);
   assign wr_en      = accept && (req_mode == stcg_pkg::MODE_WRITE)
                       && ({26'd0, req_char_slot} < 32'(MAX_CHARS));
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign issue      = issue_en && advance;

   // start position / 7 by reciprocal multiply, low by at most one
   always_comb begin
      pos9    = req_scroll_position[8:0];
      prod    = {8'd0, pos9} * 17'd146;
      q_est   = prod[16:10];
      q7      = {q_est, 3'b000} - {3'b000, q_est};
      rem_est = {1'b0, pos9} - q7;
      rem_adj = rem_est - 10'd7;
      if (rem_est >= 10'd7) begin
         q_fix = q_est + 7'd1;
         r_fix = rem_adj[OFF_W-1:0];
      end else begin
         q_fix = q_est;
         r_fix = rem_est[OFF_W-1:0];
      end
   end

   assign blank_now = p_ff[10] || (off_ff >= stcg_pkg::FONT_COLS)
                      || ({25'd0, idx_ff} >= {25'd0, msg_len_ff})
                      || ({25'd0, idx_ff} >= 32'(MAX_CHARS));
   assign rd_addr   = blank_now ? '0 : ADDR_W'(idx_ff);

   // fsm next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stcg_pkg::ST_IDLE: begin
            if (render_acc) state_in = stcg_pkg::ST_RUN;
         end
         stcg_pkg::ST_RUN: begin
            if (issue && col_ff == stcg_pkg::LAST_COL) state_in = stcg_pkg::ST_IDLE;
         end
         default: state_in = stcg_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      issue_en  = 1'b0;
      unique case (state_ff)
         stcg_pkg::ST_IDLE: req_ready = 1'b1;
         stcg_pkg::ST_RUN:  issue_en  = 1'b1;
         default: ;
      endcase
   end

   // column walk
   always_comb begin
      col_in = col_ff;
      p_in   = p_ff;
      idx_in = idx_ff;
      off_in = off_ff;
      if (render_acc) begin
         col_in = '0;
         p_in   = {req_scroll_position[9], req_scroll_position};
         if (req_scroll_position[9]) begin
            idx_in = '0;
            off_in = '0;
         end else begin
            idx_in = q_fix;
            off_in = r_fix;
         end
      end else if (issue) begin
         col_in = (col_ff == stcg_pkg::LAST_COL) ? '0 : col_ff + 3'd1;
         p_in   = p_ff + 11'sd1;
         // negative positions hold at character zero, column zero
         if (!p_ff[10]) begin
            if (off_ff == stcg_pkg::SLOT_LAST) begin
               off_in = '0;
               idx_in = idx_ff + 7'd1;
            end else begin
               off_in = off_ff + 3'd1;
            end
         end
      end
   end

   always_comb begin
      s1_vld_in            = s1_vld_ff;
      rsp_valid_in         = rsp_valid_ff;
      font_bits            = stcg_pkg::font_column(stcg_pkg::glyph_of(rd_code), s1_off_ff);
      rsp_column_pixels_in = s1_blank_ff ? 7'd0 : {1'b0, font_bits, 1'b0};
      if (advance) begin
         s1_vld_in    = issue;
         rsp_valid_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stcg_pkg::ST_IDLE;
         msg_len_ff   <= '0;
         col_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) msg_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      idx_ff <= idx_in;
      off_ff <= off_in;
      if (advance) begin
         s1_col_ff            <= col_ff;
         s1_off_ff            <= off_ff;
         s1_blank_ff          <= blank_now;
         rsp_column_index_ff  <= s1_col_ff;
         rsp_column_pixels_ff <= rsp_column_pixels_in;
         rsp_last_column_ff   <= (s1_col_ff == stcg_pkg::LAST_COL);
      end
   end

   // read data register holds while the output stalls
   stcg_ram #(
      .WIDTH (stcg_pkg::CODE_W),
      .DEPTH (MAX_CHARS)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_char_slot)),
      .wr_data (req_char_code),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (rd_code)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_index  = rsp_column_index_ff;
   assign rsp_column_pixels = rsp_column_pixels_ff;
   assign rsp_last_column   = rsp_last_column_ff;

   a_render_start: assert property (@(posedge clock) disable iff (reset)
      render_acc |=> (state_ff == stcg_pkg::ST_RUN && col_ff == '0))
      else $error("render item did not start a frame at column zero");

   a_last_is_six: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_column_ff) |-> (rsp_column_index_ff == stcg_pkg::LAST_COL))
      else $error("last column flag on wrong column");

   a_lit_in_font: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_blank_ff) |-> (s1_off_ff < stcg_pkg::FONT_COLS))
      else $error("non-blank column outside the font");

   a_idle_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == stcg_pkg::ST_IDLE) |-> (col_ff == '0))
      else $error("column counter not at zero while idle");

endmodule

// ===== rtl/stcg_ram.sv =====
module stcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/tb_scrolling_text_column_generator_core.sv =====
`timescale 1ns / 100ps

module tb_scrolling_text_column_generator_core;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 250;
   localparam int STORE_DEPTH   = stcg_pkg::MAX_CHARS_DEF;
   localparam int PHASE_ITEMS   = 48;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_RENDER,
      ROW_LENGTH
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [5:0]        slot;
      logic [7:0]        code;
      logic signed [9:0] pos;
      logic              typed;
      logic [6:0]        typed_pix;
      logic [6:0]        length;
   } stim_row_type;

   typedef struct packed {
      logic [stcg_pkg::COL_W-1:0] col;
      logic [6:0]                 pix;
      logic                       last;
   } column_result_type;

   // rows top to bottom, bit 4 leftmost font column
   localparam logic [4:0] GLYPH_ROWS [39][5] = '{
      '{5'h1E,5'h11,5'h1F,5'h11,5'h11}, '{5'h1E,5'h11,5'h1E,5'h11,5'h1F},
      '{5'h1F,5'h10,5'h10,5'h10,5'h1F}, '{5'h1E,5'h11,5'h11,5'h11,5'h1E},
      '{5'h1F,5'h10,5'h1E,5'h10,5'h1F}, '{5'h1F,5'h10,5'h1C,5'h10,5'h10},
      '{5'h1F,5'h10,5'h13,5'h11,5'h1F}, '{5'h11,5'h11,5'h1F,5'h11,5'h11},
      '{5'h0E,5'h04,5'h04,5'h04,5'h0E}, '{5'h1F,5'h02,5'h02,5'h12,5'h1E},
      '{5'h11,5'h12,5'h1C,5'h12,5'h11}, '{5'h10,5'h10,5'h10,5'h10,5'h1F},
      '{5'h11,5'h1B,5'h15,5'h11,5'h11}, '{5'h11,5'h19,5'h15,5'h13,5'h11},
      '{5'h1F,5'h11,5'h11,5'h11,5'h1F}, '{5'h1F,5'h11,5'h1F,5'h10,5'h10},
      '{5'h1E,5'h11,5'h11,5'h13,5'h1F}, '{5'h1F,5'h11,5'h1F,5'h14,5'h13},
      '{5'h1F,5'h10,5'h1F,5'h01,5'h1F}, '{5'h1F,5'h04,5'h04,5'h04,5'h04},
      '{5'h11,5'h11,5'h11,5'h11,5'h1F}, '{5'h11,5'h11,5'h11,5'h0A,5'h04},
      '{5'h11,5'h11,5'h15,5'h1B,5'h11}, '{5'h11,5'h0A,5'h04,5'h0A,5'h11},
      '{5'h11,5'h11,5'h1F,5'h04,5'h04}, '{5'h1F,5'h02,5'h04,5'h08,5'h1F},
      '{5'h1C,5'h14,5'h14,5'h14,5'h1C}, '{5'h08,5'h18,5'h08,5'h08,5'h1C},
      '{5'h1C,5'h04,5'h1C,5'h10,5'h1C}, '{5'h1C,5'h04,5'h1C,5'h04,5'h1C},
      '{5'h14,5'h14,5'h1C,5'h04,5'h04}, '{5'h1C,5'h10,5'h1C,5'h04,5'h1C},
      '{5'h1C,5'h10,5'h1C,5'h14,5'h1C}, '{5'h1C,5'h04,5'h04,5'h04,5'h04},
      '{5'h1C,5'h14,5'h1C,5'h14,5'h1C}, '{5'h1C,5'h14,5'h1C,5'h04,5'h04},
      '{5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h08,5'h08,5'h08,5'h00,5'h08},
      '{5'h00,5'h00,5'h1F,5'h00,5'h00}
   };

   // all-blank frames carry their expected pixels here, other renders go to the predictor
   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd0,    1'b1, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   -10'sd512, 1'b1, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd511,  1'b1, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd0,  "A",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd1,  "Z",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd2,  "0",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd3,  "9",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd4,  "!",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd5,  "-",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd6,  8'hFF,  10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd7,  8'h80,  10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd8,  "@",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_WRITE,  6'd9,  "[",    10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_LENGTH, 6'd0,  8'd0,   10'sd0,    1'b0, 7'h00, 7'd10},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd0,    1'b0, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd5,    1'b0, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd14,   1'b0, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd21,   1'b0, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd28,   1'b0, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd35,   1'b0, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   -10'sd3,   1'b0, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   -10'sd7,   1'b1, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd42,   1'b1, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd63,   1'b1, 7'h00, 7'd0},
      '{ROW_RENDER, 6'd0,  8'd0,   10'sd511,  1'b1, 7'h00, 7'd0}
   };

   localparam logic [6:0] PHASE_LENGTHS [6] = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd65, 7'd37};

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_wr_en = 1'b0;
   logic [stcg_pkg::LEN_W-1:0]         csr_wr_data = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic                               req_mode = stcg_pkg::MODE_WRITE;
   logic [5:0]                         req_char_slot = '0;
   logic [stcg_pkg::CODE_W-1:0]        req_char_code = '0;
   logic signed [stcg_pkg::POS_W-1:0]  req_scroll_position = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [stcg_pkg::COL_W-1:0]         rsp_column_index;
   logic [6:0]                         rsp_column_pixels;
   logic                               rsp_last_column;

   // travels with the payload: frame expectation typed in the directed rows
   logic                     cur_typed = 1'b0;
   logic [6:0]               cur_typed_pix = '0;

   logic [7:0]               text_model [STORE_DEPTH];
   logic [6:0]               length_model = '0;
   column_result_type        expected_columns [$];

   int cycles = 0;
   int errors = 0;
   int items_accepted = 0;
   int frames_rendered = 0;
   int columns_checked = 0;
   int lengths_used = 0;
   int no_gap_left = 0;
   bit hold_request = 1'b0;

   scrolling_text_column_generator_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_char_slot       (req_char_slot),
      .req_char_code       (req_char_code),
      .req_scroll_position (req_scroll_position),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_column_index    (rsp_column_index),
      .rsp_column_pixels   (rsp_column_pixels),
      .rsp_last_column     (rsp_last_column)
   );

   always #10 clock = ~clock;

   function automatic logic [stcg_pkg::GLYPH_W-1:0] glyph_index(input logic [7:0] code);
      if (code >= "A" && code <= "Z") return stcg_pkg::GLYPH_W'(code - "A");
      if (code >= "0" && code <= "9")
         return stcg_pkg::GLYPH_W'(code - "0") + stcg_pkg::DIGIT_BASE;
      if (code == "!") return stcg_pkg::FONT_BANG;
      if (code == "-") return stcg_pkg::FONT_DASH;
      return stcg_pkg::FONT_BLANK;
   endfunction

   // pixels of one matrix column at text column p
   function automatic logic [6:0] text_column_pixels(input int p);
      int shown_chars;
      int char_idx;
      int font_col;
      logic [stcg_pkg::GLYPH_W-1:0] g;
      logic [6:0] pix;
      pix = '0;
      shown_chars = (length_model > STORE_DEPTH) ? STORE_DEPTH : int'(length_model);
      if (p < 0) return pix;
      char_idx = p / 7;
      font_col = p % 7;
      if (char_idx >= shown_chars || font_col >= 5) return pix;
      g = glyph_index(text_model[char_idx]);
      for (int r = 0; r < 5; r++) pix[r + 1] = GLYPH_ROWS[g][r][4 - font_col];
      return pix;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_char_code();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 8'("A" + $urandom_range(0, 25));
      if (r < 7) return 8'("0" + $urandom_range(0, 9));
      if (r == 7) return ($urandom_range(0, 1) != 0) ? 8'("!") : 8'("-");
      return 8'($urandom_range(0, 255));
   endfunction

   // predict on accepted items, then check accepted column results
   always @(posedge clock) begin : scoreboard
      column_result_type want;
      column_result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            items_accepted++;
            if (req_mode == stcg_pkg::MODE_WRITE) begin
               text_model[req_char_slot] = req_char_code;
            end else begin
               frames_rendered++;
               for (int c = 0; c < 7; c++) begin
                  want.col  = stcg_pkg::COL_W'(c);
                  want.pix  = cur_typed ? cur_typed_pix
                                        : text_column_pixels(int'(req_scroll_position) + c);
                  want.last = (stcg_pkg::COL_W'(c) == stcg_pkg::LAST_COL);
                  expected_columns.push_back(want);
               end
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.col  = rsp_column_index;
            got.pix  = rsp_column_pixels;
            got.last = rsp_last_column;
            if (expected_columns.size() == 0) begin
               $error("unexpected column result: index %0d pixels %h", got.col, got.pix);
               errors++;
            end else begin
               want = expected_columns.pop_front();
               columns_checked++;
               if (got.col !== want.col) begin
                  $error("column_index: expected %0d, got %0d", want.col, got.col);
                  errors++;
               end
               if (got.pix !== want.pix) begin
                  $error("column_pixels: expected %h, got %h", want.pix, got.pix);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last_column: expected %0d, got %0d", want.last, got.last);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d columns outstanding",
                  cycles, expected_columns.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side back-pressure: bursts of ready, short stalls, the odd long hold
   initial begin : receiver
      int ready_left;
      int stall_left;
      ready_left = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            ready_left = 0;
            stall_left = LONG_HOLD;
         end
         if (ready_left == 0 && stall_left == 0) begin
            ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            stall_left = idle_len();
         end
         if (ready_left > 0) begin
            ready_left--;
            rsp_ready <= 1'b1;
         end else begin
            stall_left--;
            rsp_ready <= 1'b0;
         end
      end
   end

   task automatic offer_item(input logic mode, input logic [5:0] slot, input logic [7:0] code,
                             input logic signed [9:0] pos, input logic typed,
                             input logic [6:0] typed_pix);
      req_valid           <= 1'b1;
      req_mode            <= mode;
      req_char_slot       <= slot;
      req_char_code       <= code;
      req_scroll_position <= pos;
      cur_typed           <= typed;
      cur_typed_pix       <= typed_pix;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap();
      int n;
      n = 0;
      if (no_gap_left > 0) no_gap_left--;
      else if ($urandom_range(0, 19) == 0) no_gap_left = $urandom_range(10, 30);
      else n = idle_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_all_columns();
      req_valid <= 1'b0;
      // let the predictor queue the frame of the last accepted item before checking the queue
      @(posedge clock);
      while (expected_columns.size() != 0) @(posedge clock);
   endtask

   task automatic set_message_length(input logic [6:0] len);
      wait_all_columns();
      // a trailing write item leaves no result to wait for
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      length_model = len;
      lengths_used++;
   endtask

   task automatic random_item(input int n);
      logic signed [9:0] pos;
      int span;
      span = ((length_model > STORE_DEPTH) ? STORE_DEPTH : int'(length_model)) * 7 + 16;
      if ($urandom_range(0, 3) != 0) pos = 10'($urandom_range(0, span) - 8);
      else pos = 10'($urandom);
      if (n % 45 == 44) wait_all_columns();
      else sender_gap();
      if ($urandom_range(0, 99) < 55)
         offer_item(stcg_pkg::MODE_RENDER, 6'($urandom), 8'($urandom), pos, 1'b0, '0);
      else
         offer_item(stcg_pkg::MODE_WRITE, 6'($urandom), pick_char_code(), pos, 1'b0, '0);
   endtask

   initial begin : sender
      stim_row_type row;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         case (row.kind)
            ROW_LENGTH: begin
               set_message_length(row.length);
            end
            ROW_WRITE: begin
               sender_gap();
               offer_item(stcg_pkg::MODE_WRITE, row.slot, row.code, row.pos, 1'b0, '0);
            end
            default: begin
               sender_gap();
               offer_item(stcg_pkg::MODE_RENDER, row.slot, row.code, row.pos, row.typed,
                          row.typed_pix);
            end
         endcase
      end

      // fill the whole store so any length can be rendered
      for (int s = 0; s < STORE_DEPTH; s++) begin
         sender_gap();
         offer_item(stcg_pkg::MODE_WRITE, 6'(s), pick_char_code(), 10'($urandom), 1'b0, '0);
      end

      foreach (PHASE_LENGTHS[ph]) begin
         set_message_length(PHASE_LENGTHS[ph]);
         if (ph % 2 == 0) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) random_item(n);
      end

      wait_all_columns();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d items, %0d frames, %0d columns compared",
               items_accepted, frames_rendered, columns_checked);
      $display("message length set %0d times, from empty to beyond the store size",
               lengths_used);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
